// ===== hdl/fifo_queue_with_search_and_reverse_unit_macros.svh =====
// Assertion macros for the queue unit.
// Depends on nothing; included by the top level.
`ifndef FIFO_QUEUE_WITH_SEARCH_AND_REVERSE_UNIT_MACROS_SVH
`define FIFO_QUEUE_WITH_SEARCH_AND_REVERSE_UNIT_MACROS_SVH

// same-cycle implication
`define FQSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue unit check failed");

// next-cycle implication
`define FQSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue unit check failed");

`endif

// ===== hdl/fqsr_pkg.sv =====
// Package for the queue unit: field widths, command and status codes.
// No dependencies.
package fqsr_pkg;

    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int COUNT_W       = 5;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_READ = '1;

endpackage

// ===== hdl/fifo_queue_with_search_and_reverse_unit.sv =====
// Bounded FIFO queue with search and reverse, top level.
// Depends on fqsr_pkg and fifo_queue_with_search_and_reverse_unit_macros.svh.
//
// Usage:
//   A request (command, item_value) is taken at a rising edge with start high
//   and busy low. busy stays high while the request is worked on. Exactly one
//   result per request appears on read_value, found, entry_count, is_empty
//   and status for a single cycle, marked by done. The receiver cannot stall;
//   results must be captured in the done cycle.
//   The store is a single-port-write, single-port-read ring memory with a
//   registered read; a small sequencer drives it with one compare unit.
//   Enqueue, reverse, clear, unused codes and an empty dequeue or peek finish
//   in the execute state; dequeue and peek then pass through a read state;
//   contains on a nonempty queue steps through the search state, comparing
//   entries in order until a match or until all entries (at most the count)
//   have been compared.
//   A new request may be issued in the cycle done is high.
//   Reset clears head, count and direction; the store needs no clearing pass.
`include "fifo_queue_with_search_and_reverse_unit_macros.svh"

module fifo_queue_with_search_and_reverse_unit
    import fqsr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           command,
    input  logic signed [DATA_W-1:0]   item_value,
    output logic                       done,
    output logic signed [DATA_W-1:0]   read_value,
    output logic                       found,
    output logic [COUNT_W-1:0]         entry_count,
    output logic                       is_empty,
    output logic [STATUS_W-1:0]        status
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = $clog2(2 * DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SEARCH
    } state_t;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rev_reg, rev_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic                done_reg, done_next;
    logic [DATA_W-1:0]   read_value_reg, read_value_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [CNT_W-1:0]    pos_inc;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    // ring slot of logical position pos
    function automatic logic [IDX_W-1:0] slot_of(
        input logic [IDX_W-1:0] head,
        input logic [CNT_W-1:0] pos,
        input logic             rev
    );
        logic [SUM_W-1:0] s;
        if (rev)
        begin
            s = SUM_W'(head) + DEPTH_S - SUM_W'(pos);
        end
        else
        begin
            s = SUM_W'(head) + SUM_W'(pos);
        end
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[IDX_W-1:0];
    endfunction

    assign pos_inc = pos_reg + ONE_C;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        pos_next        = pos_reg;
        done_next       = 1'b0;
        read_value_next = read_value_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_of(head_reg, count_reg, rev_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    val_next   = item_value;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                read_value_next = '0;
                found_next      = 1'b0;
                status_next     = STATUS_OK;
                state_next      = ST_IDLE;
                done_next       = 1'b1;
                case (cmd_reg) inside
                    CMD_ENQUEUE:
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + ONE_C;
                        end
                    end
                    CMD_DEQUEUE, CMD_PEEK:
                    begin
                        if (count_reg == '0)
                        begin
                            read_value_next = EMPTY_READ;
                            status_next     = STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            done_next  = 1'b0;
                            state_next = ST_READ;
                        end
                    end
                    CMD_CONTAINS:
                    begin
                        if (count_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            pos_next   = '0;
                            done_next  = 1'b0;
                            state_next = ST_SEARCH;
                        end
                    end
                    CMD_REVERSE:
                    begin
                        if (count_reg != '0)
                        begin
                            head_next = slot_of(head_reg, count_reg - ONE_C, rev_reg);
                        end
                        rev_next = ~rev_reg;
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                        head_next  = '0;
                        rev_next   = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_READ:
            begin
                read_value_next = rd_data_reg;
                if (cmd_reg == CMD_DEQUEUE)
                begin
                    head_next  = slot_of(head_reg, ONE_C, rev_reg);
                    count_next = count_reg - ONE_C;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (rd_data_reg == val_reg)
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (pos_inc == count_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = slot_of(head_reg, pos_inc, rev_reg);
                    pos_next = pos_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            rev_reg        <= 1'b0;
            pos_reg        <= '0;
            done_reg       <= 1'b0;
            cmd_reg        <= CMD_ENQUEUE;
            val_reg        <= '0;
            read_value_reg <= '0;
            found_reg      <= 1'b0;
            status_reg     <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            rev_reg        <= rev_next;
            pos_reg        <= pos_next;
            done_reg       <= done_next;
            cmd_reg        <= cmd_next;
            val_reg        <= val_next;
            read_value_reg <= read_value_next;
            found_reg      <= found_next;
            status_reg     <= status_next;
        end
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign count_ext   = {{COUNT_W{1'b0}}, count_reg};
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign found       = found_reg;
    assign entry_count = count_ext[COUNT_W-1:0];
    assign is_empty    = (count_reg == '0);
    assign status      = status_reg;

    `FQSR_ASSERT_NOW(a_done_when_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `FQSR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C)
    `FQSR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done_reg)
    `FQSR_ASSERT_NOW(a_empty_result, clk, rst_n, done_reg && status_reg == STATUS_EMPTY, read_value_reg == EMPTY_READ && is_empty)
    `FQSR_ASSERT_NOW(a_full_result, clk, rst_n, done_reg && status_reg == STATUS_FULL, count_reg == DEPTH_C)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fifo_queue_with_search_and_reverse_unit.
// Runs a directed table, then random bursts; checks listed results or a queue predictor.
// Depends on fqsr_pkg and the RTL top level.
module testbench
    import fqsr_pkg::*;
;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam logic [CMD_W-1:0] CMD_NOP_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NOP_HI = 3'd7;
    localparam int RANDOM_REQUESTS = 550;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic [STATUS_W-1:0]      status;
    } queue_result_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        bit                fixed;
        queue_result_t     res;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] item_value;
    logic                     done;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic [STATUS_W-1:0]      status;

    // predicted queue contents
    logic [DATA_W-1:0] model_store [DEPTH];
    int                model_head;
    int                model_count;
    bit                model_reversed;

    queue_result_t expected_results[$];
    stim_row_t     directed_rows[$];
    bit            req_fixed;
    queue_result_t req_expect;
    bit            quiet;
    int            mismatch_count;

    fifo_queue_with_search_and_reverse_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .item_value(item_value),
        .done(done),
        .read_value(read_value),
        .found(found),
        .entry_count(entry_count),
        .is_empty(is_empty),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int ring_slot(int pos);
        if (model_reversed)
            return (model_head + DEPTH - pos) % DEPTH;
        return (model_head + pos) % DEPTH;
    endfunction

    task automatic apply_queue_command(input logic [CMD_W-1:0] cmd,
                                       input logic [DATA_W-1:0] val,
                                       output queue_result_t res);
        res = '0;
        res.status = STATUS_OK;
        case (cmd)
            CMD_ENQUEUE:
            begin
                if (model_count >= DEPTH)
                    res.status = STATUS_FULL;
                else
                begin
                    model_store[ring_slot(model_count)] = val;
                    model_count++;
                end
            end
            CMD_DEQUEUE, CMD_PEEK:
            begin
                if (model_count == 0)
                begin
                    res.read_value = EMPTY_READ;
                    res.status     = STATUS_EMPTY;
                end
                else
                begin
                    res.read_value = model_store[model_head];
                    if (cmd == CMD_DEQUEUE)
                    begin
                        model_head = ring_slot(1);
                        model_count--;
                    end
                end
            end
            CMD_CONTAINS:
            begin
                for (int i = 0; i < model_count; i++)
                    if (model_store[ring_slot(i)] == val)
                        res.found = 1'b1;
            end
            CMD_REVERSE:
            begin
                if (model_count > 0)
                    model_head = ring_slot(model_count - 1);
                model_reversed = ~model_reversed;
            end
            CMD_CLEAR:
            begin
                model_count    = 0;
                model_head     = 0;
                model_reversed = 1'b0;
            end
            default:
            begin
            end
        endcase
        res.entry_count = model_count[COUNT_W-1:0];
        res.is_empty    = (model_count == 0);
    endtask

    task automatic check_result();
        queue_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with no request pending");
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        if (read_value !== want.read_value)
        begin
            $error("read_value expected %0d got %0d", want.read_value, read_value);
            mismatch_count++;
        end
        if (found !== want.found)
        begin
            $error("found expected %0d got %0d", want.found, found);
            mismatch_count++;
        end
        if (entry_count !== want.entry_count)
        begin
            $error("entry_count expected %0d got %0d", want.entry_count, entry_count);
            mismatch_count++;
        end
        if (is_empty !== want.is_empty)
        begin
            $error("is_empty expected %0d got %0d", want.is_empty, is_empty);
            mismatch_count++;
        end
        if (status !== want.status)
        begin
            $error("status expected %0d got %0d", want.status, status);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        queue_result_t predicted;
        if (rst_n)
        begin
            if (done)
                check_result();
            if (start && !busy)
            begin
                apply_queue_command(command, item_value, predicted);
                if (req_fixed)
                    expected_results.push_back(req_expect);
                else
                    expected_results.push_back(predicted);
            end
        end
    end

    task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                                 input bit fixed, input queue_result_t res);
        while (!quiet && $urandom_range(99) < 21)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        command    = cmd;
        item_value = val;
        req_fixed  = fixed;
        req_expect = res;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic stim_row_t known_row(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val,
                                            logic [DATA_W-1:0] rd, logic f, int cnt, logic emp,
                                            logic [STATUS_W-1:0] st);
        stim_row_t r;
        r.cmd                 = cmd;
        r.val                 = val;
        r.fixed               = 1'b1;
        r.res.read_value      = rd;
        r.res.found           = f;
        r.res.entry_count     = cnt[COUNT_W-1:0];
        r.res.is_empty        = emp;
        r.res.status          = st;
        return r;
    endfunction

    function automatic stim_row_t free_row(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
        stim_row_t r;
        r.cmd   = cmd;
        r.val   = val;
        r.fixed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4, 5: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(int mode);
        int r;
        int t_enq;
        int t_deq;
        int t_peek;
        int t_cont;
        int t_rev;
        int t_clr;
        r = $urandom_range(99);
        case (mode)
            0:       begin t_enq = 60; t_deq = 72; t_peek = 80; t_cont = 90; t_rev = 96; t_clr = 97; end
            1:       begin t_enq = 20; t_deq = 65; t_peek = 75; t_cont = 87; t_rev = 95; t_clr = 97; end
            default: begin t_enq = 35; t_deq = 65; t_peek = 75; t_cont = 89; t_rev = 97; t_clr = 98; end
        endcase
        if (r < t_enq)  return CMD_ENQUEUE;
        if (r < t_deq)  return CMD_DEQUEUE;
        if (r < t_peek) return CMD_PEEK;
        if (r < t_cont) return CMD_CONTAINS;
        if (r < t_rev)  return CMD_REVERSE;
        if (r < t_clr)  return CMD_CLEAR;
        return $urandom_range(1) ? CMD_NOP_HI : CMD_NOP_LO;
    endfunction

    initial
    begin : stimulus
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        int                mode;
        int                waited;
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_ENQUEUE;
        item_value     = '0;
        req_fixed      = 1'b0;
        req_expect     = '0;
        quiet          = 1'b0;
        mismatch_count = 0;
        model_head     = 0;
        model_count    = 0;
        model_reversed = 1'b0;
        mode           = 0;
        for (int i = 0; i < DEPTH; i++)
            model_store[i] = '0;

        directed_rows.push_back(known_row(CMD_PEEK, '0, EMPTY_READ, 1'b0, 0, 1'b1,
                                          STATUS_EMPTY));
        directed_rows.push_back(known_row(CMD_DEQUEUE, 32'h7FFF_FFFF, EMPTY_READ, 1'b0, 0,
                                          1'b1, STATUS_EMPTY));
        directed_rows.push_back(known_row(CMD_CONTAINS, '0, '0, 1'b0, 0, 1'b1, STATUS_OK));
        directed_rows.push_back(known_row(CMD_REVERSE, '0, '0, 1'b0, 0, 1'b1, STATUS_OK));
        directed_rows.push_back(known_row(CMD_NOP_LO, '1, '0, 1'b0, 0, 1'b1, STATUS_OK));
        directed_rows.push_back(known_row(CMD_NOP_HI, 32'h8000_0000, '0, 1'b0, 0, 1'b1,
                                          STATUS_OK));
        directed_rows.push_back(known_row(CMD_ENQUEUE, 32'h7FFF_FFFF, '0, 1'b0, 1, 1'b0,
                                          STATUS_OK));
        directed_rows.push_back(known_row(CMD_ENQUEUE, 32'h8000_0000, '0, 1'b0, 2, 1'b0,
                                          STATUS_OK));
        directed_rows.push_back(known_row(CMD_PEEK, '0, 32'h7FFF_FFFF, 1'b0, 2, 1'b0,
                                          STATUS_OK));
        directed_rows.push_back(known_row(CMD_CONTAINS, 32'h8000_0000, '0, 1'b1, 2, 1'b0,
                                          STATUS_OK));
        directed_rows.push_back(known_row(CMD_CONTAINS, '0, '0, 1'b0, 2, 1'b0, STATUS_OK));
        directed_rows.push_back(known_row(CMD_REVERSE, '0, '0, 1'b0, 2, 1'b0, STATUS_OK));
        directed_rows.push_back(known_row(CMD_PEEK, '0, 32'h8000_0000, 1'b0, 2, 1'b0,
                                          STATUS_OK));
        directed_rows.push_back(free_row(CMD_ENQUEUE, 32'h0000_0005));
        directed_rows.push_back(free_row(CMD_DEQUEUE, '0));
        directed_rows.push_back(free_row(CMD_DEQUEUE, '0));
        directed_rows.push_back(free_row(CMD_CONTAINS, 32'h0000_0005));
        directed_rows.push_back(known_row(CMD_CLEAR, '0, '0, 1'b0, 0, 1'b1, STATUS_OK));
        directed_rows.push_back(known_row(CMD_ENQUEUE, '1, '0, 1'b0, 1, 1'b0, STATUS_OK));
        directed_rows.push_back(known_row(CMD_REVERSE, '0, '0, 1'b0, 1, 1'b0, STATUS_OK));
        directed_rows.push_back(known_row(CMD_DEQUEUE, '0, '1, 1'b0, 0, 1'b1, STATUS_OK));
        directed_rows.push_back(free_row(CMD_ENQUEUE, 32'h1234_5678));
        directed_rows.push_back(free_row(CMD_ENQUEUE, 32'hEDCB_A987));
        directed_rows.push_back(free_row(CMD_REVERSE, '0));
        directed_rows.push_back(free_row(CMD_PEEK, '0));

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].cmd, directed_rows[i].val,
                          directed_rows[i].fixed, directed_rows[i].res);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 40 == 0)
                mode = $urandom_range(2);
            quiet = (n >= 250 && n < 350);
            cmd   = pick_command(mode);
            val   = pick_value();
            if (cmd == CMD_CONTAINS && model_count > 0 && $urandom_range(1))
                val = model_store[ring_slot($urandom_range(model_count - 1))];
            issue_request(cmd, val, 1'b0, '0);
        end
        start = 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end
        repeat (2 * DEPTH + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== fifo_queue_with_search_and_reverse_unit.f =====
+incdir+hdl
hdl/fqsr_pkg.sv
hdl/fifo_queue_with_search_and_reverse_unit.sv
dv/testbench.sv
